[design/pcxd_pkg.sv]
// ----------------------------------------------------------------------------
// pcxd_pkg
// Types and constants shared by the PCX run-length image decoder modules.
// ----------------------------------------------------------------------------
package pcxd_pkg;

    // Limits of the decoded image
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_BYTES = 768;

    // Byte codes of the stream
    localparam logic [7:0] RUN_HDR_MIN = 8'd192;
    localparam logic [7:0] PAL_MARKER  = 8'd12;

    // Register indexes on the APB port
    typedef enum logic [2:0] {
        REG_COMPRESS_ON     = 3'd0,
        REG_IMAGE_WIDTH     = 3'd1,
        REG_IMAGE_HEIGHT    = 3'd2,
        REG_LINE_STRIDE     = 3'd3,
        REG_PALETTE_FOLLOWS = 3'd4
    } t_reg_idx;

    // Stream phase
    typedef enum logic [1:0] {
        PH_PIXEL   = 2'd0,
        PH_MARKER  = 2'd1,
        PH_PALETTE = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // Item kind codes
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    // Configuration registers
    typedef struct packed {
        logic        compress_on;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] line_stride;
        logic        palette_follows;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic        item_kind;
        logic [11:0] column;
        logic [11:0] row;
        logic [9:0]  palette_slot;
        logic [7:0]  value;
        logic        marker_missing;
        logic        all_done;
        logic        last;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic flush;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic needs_run;
        logic step_last;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

[design/pcx_rle_image_decoder.sv]
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder
// PCX run-length pixel stream decoder with palette pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one raw file byte per request (after the header) on
//   i_raw_byte, i_in_valid / o_in_stall. Output channel: one pixel or
//   palette byte per request, o_out_valid / i_out_stall, with column, row,
//   palette slot, value, marker flag, all_done and last.
//   Configure over the APB port only while idle; pready is tied high.
//   A run header or marker byte is only accepted. A literal or
//   palette byte goes through accept, decode and flush, and a run is
//   expanded one decoded byte per cycle through the line position
//   counter while the receiver does not stall. Each result is held one
//   stage before the output register so that the last flag of its byte
//   can be set.
//   Reset returns the decoder to the first pixel of row 0 with the
//   registers at their defaults. A stalled receiver holds the output
//   register and halts run expansion; the input is stalled meanwhile.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder
    import pcxd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel stream in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_raw_byte,
    // Result stream out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_item_kind,
    output logic [11:0] o_column,
    output logic [11:0] o_row,
    output logic [9:0]  o_palette_slot,
    output logic [7:0]  o_value,
    output logic        o_marker_missing,
    output logic        o_all_done,
    output logic        o_last,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    t_cmd     cmd;
    t_status  status;
    t_result  out_item;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.compress_on     <= 1'b1;
            r_cfg.image_width     <= 13'd1;
            r_cfg.image_height    <= 13'd1;
            r_cfg.line_stride     <= 16'd0;
            r_cfg.palette_follows <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_COMPRESS_ON:     r_cfg.compress_on     <= pwdata[0];
                REG_IMAGE_WIDTH:     r_cfg.image_width     <= pwdata[12:0];
                REG_IMAGE_HEIGHT:    r_cfg.image_height    <= pwdata[12:0];
                REG_LINE_STRIDE:     r_cfg.line_stride     <= pwdata[15:0];
                REG_PALETTE_FOLLOWS: r_cfg.palette_follows <= pwdata[0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_COMPRESS_ON:     prdata = {31'd0, r_cfg.compress_on};
            REG_IMAGE_WIDTH:     prdata = {19'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT:    prdata = {19'd0, r_cfg.image_height};
            REG_LINE_STRIDE:     prdata = {16'd0, r_cfg.line_stride};
            REG_PALETTE_FOLLOWS: prdata = {31'd0, r_cfg.palette_follows};
            default:             prdata = 32'd0;
        endcase
    end

    pcxd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pcxd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_raw_byte  (i_raw_byte),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (out_item)
    );

    assign o_item_kind      = out_item.item_kind;
    assign o_column         = out_item.column;
    assign o_row            = out_item.row;
    assign o_palette_slot   = out_item.palette_slot;
    assign o_value          = out_item.value;
    assign o_marker_missing = out_item.marker_missing;
    assign o_all_done       = out_item.all_done;
    assign o_last           = out_item.last;

endmodule

[design/pcxd_ctrl.sv]
// ----------------------------------------------------------------------------
// pcxd_ctrl
// Sequencer: takes a raw byte; for a literal, run value or palette byte it
// steps the datapath once per decoded byte, then flushes the held result with its last flag.
// ----------------------------------------------------------------------------
module pcxd_ctrl
    import pcxd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.needs_run) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.out_free && i_status.step_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.flush  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = i_status.out_free;
            end
            ST_FLUSH: begin
                o_cmd.flush = i_status.pend_valid && i_status.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

[design/pcxd_dpath.sv]
// ----------------------------------------------------------------------------
// pcxd_dpath
// Decode state, line and palette counters, a one-deep holding stage that
// lets the last flag be set, and the output register.
// ----------------------------------------------------------------------------
module pcxd_dpath
    import pcxd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic [7:0]  i_raw_byte,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_result     o_out
);

    // Decode state
    t_phase      r_phase,      n_phase;
    logic        r_await,      n_await;
    logic [5:0]  r_run_len,    n_run_len;
    logic [15:0] r_lbp,        n_lbp;
    logic [11:0] r_line,       n_line;
    logic [9:0]  r_pal_pos,    n_pal_pos;
    logic        r_marker_bad, n_marker_bad;
    logic [7:0]  r_value,      n_value;
    logic [5:0]  r_count,      n_count;

    // Holding stage and output register
    logic    r_pend_valid;
    t_result r_pend;
    logic    r_out_valid;
    t_result r_out;

    // Step helpers
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] span;
    logic        final_row;
    logic [16:0] lbp_inc;
    logic        line_wrap;
    logic        pal_end;
    logic        is_hdr;
    logic        cand_valid;
    t_result     cand;
    logic        out_free;
    logic        push;
    logic        leaves;

    // Clamped geometry
    always_comb begin
        if (i_cfg.image_width == 13'd0) begin
            w = 13'd1;
        end else if (i_cfg.image_width > 13'(MAX_WIDTH)) begin
            w = 13'(MAX_WIDTH);
        end else begin
            w = i_cfg.image_width;
        end
        if (i_cfg.image_height == 13'd0) begin
            h = 13'd1;
        end else if (i_cfg.image_height > 13'(MAX_HEIGHT)) begin
            h = 13'(MAX_HEIGHT);
        end else begin
            h = i_cfg.image_height;
        end
    end

    assign span      = (i_cfg.line_stride > {3'b0, w}) ? i_cfg.line_stride : {3'b0, w};
    assign final_row = ({1'b0, r_line} + 13'd1) >= h;
    assign lbp_inc   = {1'b0, r_lbp} + 17'd1;
    assign line_wrap = lbp_inc >= {1'b0, span};
    assign pal_end   = ({1'b0, r_pal_pos} + 11'd1) >= 11'(PALETTE_BYTES);
    assign is_hdr    = i_cfg.compress_on && (i_raw_byte >= RUN_HDR_MIN);

    // Candidate result of one decoded byte
    always_comb begin
        cand       = '0;
        cand_valid = 1'b0;
        cand.value = r_value;
        if (r_phase == PH_PALETTE) begin
            cand_valid          = 1'b1;
            cand.item_kind      = KIND_PALETTE;
            cand.palette_slot   = r_pal_pos;
            cand.marker_missing = r_marker_bad;
            cand.all_done       = pal_end;
        end else begin
            cand_valid     = r_lbp < {3'b0, w};
            cand.item_kind = KIND_PIXEL;
            cand.column    = r_lbp[11:0];
            cand.row       = r_line;
            cand.all_done  = final_row && (lbp_inc == {4'b0, w})
                             && !i_cfg.palette_follows;
        end
    end

    // Next decode state
    always_comb begin
        n_phase      = r_phase;
        n_await      = r_await;
        n_run_len    = r_run_len;
        n_lbp        = r_lbp;
        n_line       = r_line;
        n_pal_pos    = r_pal_pos;
        n_marker_bad = r_marker_bad;
        n_value      = r_value;
        n_count      = r_count;
        leaves       = 1'b0;
        if (i_cmd.accept) begin
            case (r_phase)
                PH_PIXEL: begin
                    if (r_await) begin
                        n_value   = i_raw_byte;
                        n_count   = (r_run_len == 6'd0) ? 6'd1 : r_run_len;
                        n_await   = 1'b0;
                        n_run_len = 6'd0;
                    end else if (is_hdr) begin
                        n_await   = 1'b1;
                        n_run_len = i_raw_byte[5:0];
                    end else begin
                        n_value = i_raw_byte;
                        n_count = 6'd1;
                    end
                end
                PH_MARKER: begin
                    n_marker_bad = i_raw_byte != PAL_MARKER;
                    n_pal_pos    = 10'd0;
                    n_phase      = PH_PALETTE;
                end
                PH_PALETTE: begin
                    n_value = i_raw_byte;
                    n_count = 6'd1;
                end
                default: n_phase = r_phase;
            endcase
        end else if (i_cmd.step) begin
            n_count = r_count - 6'd1;
            if (r_phase == PH_PALETTE) begin
                leaves = pal_end;
                if (pal_end) begin
                    n_phase   = PH_DONE;
                    n_pal_pos = 10'd0;
                end else begin
                    n_pal_pos = r_pal_pos + 10'd1;
                end
            end else begin
                // Advance along the line; the last row ends the pixels
                if (line_wrap) begin
                    n_lbp = 16'd0;
                    if (final_row) begin
                        leaves    = 1'b1;
                        n_line    = 12'd0;
                        n_phase   = i_cfg.palette_follows ? PH_MARKER : PH_DONE;
                        n_await   = 1'b0;
                        n_run_len = 6'd0;
                    end else begin
                        n_line = r_line + 12'd1;
                    end
                end else begin
                    n_lbp = lbp_inc[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PIXEL;
            r_await      <= 1'b0;
            r_run_len    <= 6'd0;
            r_lbp        <= 16'd0;
            r_line       <= 12'd0;
            r_pal_pos    <= 10'd0;
            r_marker_bad <= 1'b0;
            r_count      <= 6'd0;
        end else begin
            r_phase      <= n_phase;
            r_await      <= n_await;
            r_run_len    <= n_run_len;
            r_lbp        <= n_lbp;
            r_line       <= n_line;
            r_pal_pos    <= n_pal_pos;
            r_marker_bad <= n_marker_bad;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Holding stage: a result waits until the next one shows it was not the last
    assign out_free = !r_out_valid || !i_out_stall;
    assign push     = (i_cmd.step && cand_valid && r_pend_valid) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && cand_valid) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && cand_valid) begin
            r_pend <= cand;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // last flag is bit 0 of the result
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= {r_pend[$bits(t_result)-1:1], i_cmd.flush};
        end
    end

    // Status
    always_comb begin
        o_status.needs_run  = ((r_phase == PH_PIXEL) && (r_await || !is_hdr))
                              || (r_phase == PH_PALETTE);
        o_status.step_last  = (r_count == 6'd1) || leaves;
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[bench/pcx_rle_image_decoder_test.sv]
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder_test
// Self-checking bench for the PCX run-length image decoder. One image is
// decoded per run: a scripted opening (literals, runs, register changes
// mid-stream, clamped sizes), a random pixel stream, the final row with
// its end flag, the palette marker and the first palette bytes. Every result
// is compared field by field with a scripted answer or an in-bench model.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pcxd_pkg::*;

    localparam int DRAIN_CYCLES  = 80;    // covers a run of 63 copies into padding
    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 60;
    localparam int END_WIDTH     = 3;
    localparam int END_STRIDE    = 6;
    localparam int PALETTE_SENT  = 100;

    // Scripted opening: register writes and bytes, some with a fixed answer
    typedef struct {
        bit          is_reg;
        t_reg_idx    idx;
        logic [31:0] data;
        bit          typed;
        t_result     want;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_raw_byte  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_item_kind;
    logic [11:0] o_column;
    logic [11:0] o_row;
    logic [9:0]  o_palette_slot;
    logic [7:0]  o_value;
    logic        o_marker_missing;
    logic        o_all_done;
    logic        o_last;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model state and register copy
    t_cfg        cfg_copy = '{1'b1, 13'd1, 13'd1, 16'd0, 1'b0};
    t_phase      ph       = PH_PIXEL;
    bit          awaiting_value;
    bit [5:0]    run_len;
    int          line_pos;
    bit [11:0]   line_no;
    bit [9:0]    pal_pos;
    bit          marker_bad;

    t_result     byte_items[$];   // results of the byte just decoded
    t_result     items_due[$];    // results still to come from the block
    t_script_row script[$];
    int          bad_items;
    bit          tx_calm;
    bit          rx_calm;
    bit          hold_req;

    pcx_rle_image_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_byte       (i_raw_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_item_kind      (o_item_kind),
        .o_column         (o_column),
        .o_row            (o_row),
        .o_palette_slot   (o_palette_slot),
        .o_value          (o_value),
        .o_marker_missing (o_marker_missing),
        .o_all_done       (o_all_done),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // One decoded byte lands in the line: pixel or padding
    function automatic void place_pixel_byte(logic [7:0] v);
        int      w;
        int      h;
        int      span;
        bit      final_row;
        t_result r;
        w = cfg_copy.image_width;
        h = cfg_copy.image_height;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        span = (int'(cfg_copy.line_stride) > w) ? int'(cfg_copy.line_stride) : w;
        final_row = (int'(line_no) + 1) >= h;
        if (line_pos < w) begin
            r = '0;
            r.item_kind = KIND_PIXEL;
            r.column    = line_pos[11:0];
            r.row       = line_no;
            r.value     = v;
            r.all_done  = final_row && (line_pos + 1 == w) && !cfg_copy.palette_follows;
            byte_items.push_back(r);
        end
        line_pos++;
        if (line_pos >= span) begin
            line_pos = 0;
            if (final_row) begin
                line_no = '0;
                ph = cfg_copy.palette_follows ? PH_MARKER : PH_DONE;
            end else begin
                line_no = line_no + 12'd1;
            end
        end
    endfunction

    // Results caused by one raw byte of the stream
    function automatic void decode_raw_byte(logic [7:0] b);
        int      count;
        int      i;
        t_result r;
        byte_items.delete();
        case (ph)
            PH_PIXEL: begin
                if (awaiting_value) begin
                    count = (run_len != 0) ? int'(run_len) : 1;
                    awaiting_value = 1'b0;
                    run_len = '0;
                    for (i = 0; i < count && ph == PH_PIXEL; i++)
                        place_pixel_byte(b);
                end else if (cfg_copy.compress_on && b >= RUN_HDR_MIN) begin
                    awaiting_value = 1'b1;
                    run_len = b[5:0];
                end else begin
                    place_pixel_byte(b);
                end
                // copies left over at the end of the pixels are dropped
                if (ph != PH_PIXEL) begin
                    awaiting_value = 1'b0;
                    run_len = '0;
                end
            end
            PH_MARKER: begin
                marker_bad = (b != PAL_MARKER);
                pal_pos = '0;
                ph = PH_PALETTE;
            end
            PH_PALETTE: begin
                r = '0;
                r.item_kind      = KIND_PALETTE;
                r.palette_slot   = pal_pos;
                r.value          = b;
                r.marker_missing = marker_bad;
                r.all_done       = (int'(pal_pos) + 1 >= PALETTE_BYTES);
                byte_items.push_back(r);
                if (r.all_done) begin
                    ph = PH_DONE;
                    pal_pos = '0;
                end else begin
                    pal_pos = pal_pos + 10'd1;
                end
            end
            default: ;
        endcase
        if (byte_items.size() > 0)
            byte_items[byte_items.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_reg(t_reg_idx idx, logic [31:0] data);
        t_script_row r;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        r.typed  = 1'b0;
        r.want   = '0;
        script.push_back(r);
    endfunction

    // typed rows are single pixels on row 0 that end their request
    function automatic void add_byte(logic [7:0] b, bit typed, logic [11:0] col);
        t_script_row r;
        r.is_reg         = 1'b0;
        r.idx            = REG_COMPRESS_ON;
        r.data           = b;
        r.typed          = typed;
        r.want           = '0;
        r.want.item_kind = KIND_PIXEL;
        r.want.column    = col;
        r.want.value     = b;
        r.want.last      = 1'b1;
        script.push_back(r);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            bad_items++;
        end
    endfunction

    // Offer one byte, wait for the request to be taken, then predict
    task automatic send_byte(logic [7:0] b, bit typed, t_result want);
        int gap;
        if ($urandom_range(0, 47) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        decode_raw_byte(b);
        if (typed) begin
            items_due.push_back(want);
        end else begin
            foreach (byte_items[k]) items_due.push_back(byte_items[k]);
        end
    endtask

    // Quiet the input and let the block drain before a register write
    task automatic settle();
        i_in_valid <= 1'b0;
        while (items_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COMPRESS_ON:     cfg_copy.compress_on     = data[0];
            REG_IMAGE_WIDTH:     cfg_copy.image_width     = data[12:0];
            REG_IMAGE_HEIGHT:    cfg_copy.image_height    = data[12:0];
            REG_LINE_STRIDE:     cfg_copy.line_stride     = data[15:0];
            REG_PALETTE_FOLLOWS: cfg_copy.palette_follows = data[0];
            default: ;
        endcase
    endtask

    // Receiver: random hold-off per request, one long hold on demand
    initial begin : result_sink
        int gap;
        forever begin
            if ($urandom_range(0, 47) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 17);
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    // Result check against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_item_kind, o_column, o_row, o_palette_slot, o_value,
                    o_marker_missing, o_all_done, o_last};
            if (items_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                bad_items++;
            end else begin
                want = items_due.pop_front();
                compare_field("item_kind", want.item_kind, got.item_kind);
                compare_field("column", want.column, got.column);
                compare_field("row", want.row, got.row);
                compare_field("palette_slot", want.palette_slot, got.palette_slot);
                compare_field("value", want.value, got.value);
                compare_field("marker_missing", want.marker_missing, got.marker_missing);
                compare_field("all_done", want.all_done, got.all_done);
                compare_field("last", want.last, got.last);
            end
        end
    end

    // Watchdog on cycles with no request taken on either side
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        int   phase_no;
        int   sent;
        int   pick;
        int   len;
        // opening script: extremes, count of zero, header value as data,
        // compression cleared between header and value, clamped sizes
        add_reg(REG_COMPRESS_ON, 1);
        add_reg(REG_IMAGE_WIDTH, 5);
        add_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        add_reg(REG_LINE_STRIDE, 7);
        add_reg(REG_PALETTE_FOLLOWS, 0);
        add_byte(8'h00, 1'b1, 12'd0);
        add_byte(RUN_HDR_MIN - 8'd1, 1'b1, 12'd1);
        add_byte(RUN_HDR_MIN, 1'b0, '0);
        add_byte(8'h7E, 1'b1, 12'd2);
        add_byte(RUN_HDR_MIN | 8'h3F, 1'b0, '0);
        add_byte(8'hFF, 1'b0, '0);
        add_reg(REG_COMPRESS_ON, 0);
        add_byte(8'hD5, 1'b0, '0);
        add_reg(REG_COMPRESS_ON, 1);
        add_byte(RUN_HDR_MIN + 8'd3, 1'b0, '0);
        add_reg(REG_COMPRESS_ON, 0);
        add_byte(8'hE0, 1'b0, '0);
        add_reg(REG_COMPRESS_ON, 1);
        add_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        add_reg(REG_LINE_STRIDE, 16'hFFFF);
        add_byte(RUN_HDR_MIN + 8'd5, 1'b0, '0);
        add_byte(8'h33, 1'b0, '0);
        add_reg(REG_IMAGE_WIDTH, 0);
        add_reg(REG_LINE_STRIDE, 0);
        add_byte(8'h44, 1'b0, '0);
        add_byte(8'h55, 1'b0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[s]) begin
            if (script[s].is_reg) begin
                settle();
                write_reg(script[s].idx, script[s].data);
            end else begin
                send_byte(script[s].data[7:0], script[s].typed, script[s].want);
            end
        end

        // random pixel stream, mostly literals and whole runs
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            settle();
            write_reg(REG_COMPRESS_ON, $urandom_range(0, 3) != 0);
            write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(17, 300) : $urandom_range(1, 16));
            write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 1) ? MAX_HEIGHT : 13'h1FFF);
            write_reg(REG_LINE_STRIDE, $urandom_range(4, 24));
            write_reg(REG_PALETTE_FOLLOWS, $urandom_range(0, 1));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (phase_no == 2 && sent == 10) hold_req = 1'b1;
                pick = $urandom_range(0, 99);
                if (!cfg_copy.compress_on) begin
                    send_byte($urandom_range(0, 255), 1'b0, '0);
                    sent += 1;
                end else if (pick < 50) begin
                    send_byte($urandom_range(0, RUN_HDR_MIN - 1), 1'b0, '0);
                    sent += 1;
                end else if (pick < 92) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 7);
                    send_byte(RUN_HDR_MIN + len, 1'b0, '0);
                    send_byte($urandom_range(0, 255), 1'b0, '0);
                    sent += 2;
                end else begin
                    send_byte($urandom_range(0, 255), 1'b0, '0);
                    sent += 1;
                end
            end
        end

        // close a pending run, then line up at the start of a line
        settle();
        if (awaiting_value) send_byte($urandom_range(0, 255), 1'b0, '0);
        settle();
        write_reg(REG_COMPRESS_ON, 1);
        write_reg(REG_IMAGE_WIDTH, END_WIDTH);
        write_reg(REG_LINE_STRIDE, END_STRIDE);
        while (line_pos != 0) send_byte($urandom_range(0, RUN_HDR_MIN - 1), 1'b0, '0);

        // height below the current row: this line is the last one;
        // without a palette its last pixel ends the image
        settle();
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_PALETTE_FOLLOWS, 0);
        while (line_pos < END_WIDTH) send_byte($urandom_range(0, RUN_HDR_MIN - 1), 1'b0, '0);

        // palette switched on in the padding; a long run ends the pixels
        settle();
        write_reg(REG_PALETTE_FOLLOWS, 1);
        send_byte(RUN_HDR_MIN | 8'h3F, 1'b0, '0);
        send_byte($urandom_range(0, 255), 1'b0, '0);

        // marker, then the opening stretch of the palette
        send_byte($urandom_range(0, 1) ? PAL_MARKER : 8'($urandom_range(0, 255)), 1'b0, '0);
        repeat (PALETTE_SENT) send_byte($urandom_range(0, 255), 1'b0, '0);

        settle();
        if (bad_items == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[pcx_rle_image_decoder.f]
design/pcxd_pkg.sv
design/pcxd_ctrl.sv
design/pcxd_dpath.sv
design/pcx_rle_image_decoder.sv
bench/pcx_rle_image_decoder_test.sv
